// File: rtl/ulpc_pkg.sv
// Shared types, constants and helper functions for the UPS load protection controller.
// Depends on nothing; the top level takes everything from here.
package ulpc_pkg;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_MEASURE = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_t;

  // Power-cycle phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_WAIT_CUT = 2'd1,
    PH_HOLD_OFF = 2'd2
  } phase_t;

  // Restart request status
  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_NO_TARGET = 3'd1,
    ST_BUSY      = 3'd2,
    ST_MODE_OFF  = 3'd3,
    ST_BATT_LOW  = 3'd4,
    ST_NO_REQ    = 3'd5
  } status_t;

  // Battery level codes
  typedef enum logic [1:0] {
    LVL_OK       = 2'd0,
    LVL_WARNING  = 2'd1,
    LVL_CRITICAL = 2'd2
  } level_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_BATT_CUTOFF  = 3'd0,
    CFG_BATT_WARN    = 3'd1,
    CFG_BATT_RESTORE = 3'd2,
    CFG_GRID_OFF     = 3'd3,
    CFG_GRID_ON      = 3'd4,
    CFG_GRID_DEBOUNCE = 3'd5,
    CFG_LOAD_MODES   = 3'd6
  } cfg_idx_t;

  // Channel mode that forces a channel off
  localparam logic [1:0] MODE_OFF = 2'd2;

  // Channel positions in a target or mode field
  localparam int CH_ROUTER = 0;
  localparam int CH_ONT    = 1;

  // Event flag bit positions
  localparam int EV_GRID_BACK  = 0;
  localparam int EV_GRID_LOST  = 1;
  localparam int EV_DISCONNECT = 2;
  localparam int EV_BATT_WARN  = 3;

  // Timing and margin constants
  localparam logic [31:0] OFF_HOLD_MS         = 32'd5000;
  localparam logic [31:0] MANUAL_DELAY_MS     = 32'd1000;
  localparam logic [31:0] AUTO_DELAY_MS       = 32'd250;
  localparam logic [16:0] WARN_CLEAR_MARGIN_MV = 17'd300;

  // Reset values of the configuration registers
  localparam logic [15:0] RST_BATT_CUTOFF   = 16'd11000;
  localparam logic [15:0] RST_BATT_WARN     = 16'd11800;
  localparam logic [15:0] RST_BATT_RESTORE  = 16'd12400;
  localparam logic [15:0] RST_GRID_OFF      = 16'd18000;
  localparam logic [15:0] RST_GRID_ON       = 16'd20000;
  localparam logic [15:0] RST_GRID_DEBOUNCE = 16'd2000;

  // True when the two-bit mode of a channel forces it off
  function automatic logic mode_off(input logic [3:0] modes, input int ch);
    logic [1:0] m;
    m = (ch == CH_ONT) ? modes[3:2] : modes[1:0];
    return (m == MODE_OFF);
  endfunction

  // Battery check with restore hysteresis while the disconnect is latched
  function automatic logic batt_allows(input logic lvd, input logic [15:0] vb,
                                       input logic [15:0] cutoff,
                                       input logic [15:0] restore);
    return lvd ? (vb >= restore) : (vb > cutoff);
  endfunction

endpackage

// File: rtl/ups_load_protection_controller_top.sv
// Top level of the two-channel UPS load protection controller.
// Depends on ulpc_pkg for types, codes, constants and helper functions.

// The block takes one item per clock cycle while in_stall is low and returns
// exactly one result per item: the item is first captured in an input
// register, all decisions (power-cycle deadline, grid hysteresis and
// debounce, outage timing, low-voltage disconnect, channel modes, warning)
// are made in one pass of compare-and-select logic, and the result lands in
// an output register together with the updated controller state. in_stall
// rises only when both registers hold items and out_stall is high.
// cfg_ready is always high; write configuration only while no item is in
// flight. A write to index 7 is accepted and ignored.
module ups_load_protection_controller_top (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_command,
  input  logic [31:0]             in_now_ms,
  input  logic [15:0]             in_vbatt_mv,
  input  logic [15:0]             in_vgrid_mv,
  input  logic [1:0]              in_target,
  input  logic                    in_automatic_req,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_router_on,
  output logic                    out_ont_on,
  output logic                    out_grid_ok,
  output logic [1:0]              out_battery_level,
  output logic                    out_disconnect_active,
  output logic [1:0]              out_cycle_phase,
  output logic [2:0]              out_request_status,
  output logic [3:0]              out_event_flags,
  output logic [31:0]             out_outage_total,
  output logic [31:0]             out_last_outage_ms,
  output logic                    out_recheck_network,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_data
);
  import ulpc_pkg::*;

  // ---------------------------------------------------------------- config
  logic [15:0] batt_cutoff_r, batt_warn_r, batt_restore_r;
  logic [15:0] grid_off_r, grid_on_r, grid_debounce_r;
  logic [3:0]  load_modes_r;

  assign cfg_ready = 1'b1;

  // Write one configuration register per handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batt_cutoff_r   <= RST_BATT_CUTOFF;
      batt_warn_r     <= RST_BATT_WARN;
      batt_restore_r  <= RST_BATT_RESTORE;
      grid_off_r      <= RST_GRID_OFF;
      grid_on_r       <= RST_GRID_ON;
      grid_debounce_r <= RST_GRID_DEBOUNCE;
      load_modes_r    <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BATT_CUTOFF:   batt_cutoff_r   <= cfg_data;
        CFG_BATT_WARN:     batt_warn_r     <= cfg_data;
        CFG_BATT_RESTORE:  batt_restore_r  <= cfg_data;
        CFG_GRID_OFF:      grid_off_r      <= cfg_data;
        CFG_GRID_ON:       grid_on_r       <= cfg_data;
        CFG_GRID_DEBOUNCE: grid_debounce_r <= cfg_data;
        CFG_LOAD_MODES:    load_modes_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- handshake
  logic        s1_valid_r;
  logic [1:0]  s1_command_r;
  logic [31:0] s1_now_r;
  logic [15:0] s1_vbatt_r, s1_vgrid_r;
  logic [1:0]  s1_target_r;
  logic        s1_auto_r;
  logic        out_valid_r;
  logic        out_free, s1_fire, in_fire;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // Capture an item whenever the input register is free or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_command_r <= in_command;
      s1_now_r     <= in_now_ms;
      s1_vbatt_r   <= in_vbatt_mv;
      s1_vgrid_r   <= in_vgrid_mv;
      s1_target_r  <= in_target;
      s1_auto_r    <= in_automatic_req;
    end
  end

  // --------------------------------------------------------------- state
  logic        router_en_r, router_en_nxt;
  logic        ont_en_r, ont_en_nxt;
  logic        grid_present_r, grid_present_nxt;
  logic        grid_cand_r, grid_cand_nxt;
  logic [31:0] grid_change_r, grid_change_nxt;
  logic        lvd_r, lvd_nxt;
  logic        warn_sent_r, warn_sent_nxt;
  logic [15:0] last_batt_r, last_batt_nxt;
  logic        outage_run_r, outage_run_nxt;
  logic [31:0] outage_start_r, outage_start_nxt;
  logic [31:0] outage_count_r, outage_count_nxt;
  logic [31:0] outage_dur_r, outage_dur_nxt;
  phase_t      cyc_state_r, cyc_state_nxt;
  logic [1:0]  cyc_target_r, cyc_target_nxt;
  logic [31:0] cyc_deadline_r, cyc_deadline_nxt;
  logic        cyc_auto_r, cyc_auto_nxt;

  // Per-item results
  status_t     status_nxt;
  logic [3:0]  ev_nxt;
  logic        recheck_nxt;
  level_t      level_nxt;

  // Intermediate values of the single pass
  logic [31:0] dl_diff;
  logic [31:0] grid_age;
  logic        grid_meas;
  logic        act;
  logic [16:0] warn_clear;

  // One pass over the item: deadline check, then measurement or restart
  always_comb begin
    router_en_nxt    = router_en_r;
    ont_en_nxt       = ont_en_r;
    grid_present_nxt = grid_present_r;
    grid_cand_nxt    = grid_cand_r;
    grid_change_nxt  = grid_change_r;
    lvd_nxt          = lvd_r;
    warn_sent_nxt    = warn_sent_r;
    last_batt_nxt    = last_batt_r;
    outage_run_nxt   = outage_run_r;
    outage_start_nxt = outage_start_r;
    outage_count_nxt = outage_count_r;
    outage_dur_nxt   = outage_dur_r;
    cyc_state_nxt    = cyc_state_r;
    cyc_target_nxt   = cyc_target_r;
    cyc_deadline_nxt = cyc_deadline_r;
    cyc_auto_nxt     = cyc_auto_r;
    status_nxt       = ST_NO_REQ;
    ev_nxt           = 4'd0;
    recheck_nxt      = 1'b0;
    grid_meas        = 1'b0;
    grid_age         = 32'd0;
    act              = 1'b1;
    warn_clear       = {1'b0, batt_warn_r} + WARN_CLEAR_MARGIN_MV;

    // Power-cycle deadline: cut the targets, or end the hold and restore them or latch the disconnect
    dl_diff = s1_now_r - cyc_deadline_r;
    if (cyc_state_r != PH_IDLE && !dl_diff[31]) begin
      if (cyc_state_r == PH_WAIT_CUT) begin
        if (cyc_target_r[CH_ROUTER]) router_en_nxt = 1'b0;
        if (cyc_target_r[CH_ONT])    ont_en_nxt    = 1'b0;
        cyc_state_nxt    = PH_HOLD_OFF;
        cyc_deadline_nxt = s1_now_r + OFF_HOLD_MS;
      end else begin
        cyc_state_nxt  = PH_IDLE;
        cyc_target_nxt = 2'd0;
        cyc_auto_nxt   = 1'b0;
        if (!(grid_present_r ||
              batt_allows(lvd_r, last_batt_r, batt_cutoff_r, batt_restore_r))) begin
          lvd_nxt = 1'b1;
        end else begin
          if (cyc_target_r[CH_ROUTER] && !mode_off(load_modes_r, CH_ROUTER))
            router_en_nxt = 1'b1;
          if (cyc_target_r[CH_ONT] && !mode_off(load_modes_r, CH_ONT))
            ont_en_nxt = 1'b1;
          lvd_nxt     = 1'b0;
          recheck_nxt = 1'b1;
        end
      end
    end

    case (s1_command_r)
      CMD_MEASURE: begin
        last_batt_nxt = s1_vbatt_r;
        // Grid presence with voltage hysteresis and debounce
        grid_meas = grid_present_nxt ? (s1_vgrid_r > grid_off_r) : (s1_vgrid_r > grid_on_r);
        if (grid_meas != grid_cand_nxt) begin
          grid_cand_nxt   = grid_meas;
          grid_change_nxt = s1_now_r;
        end
        grid_age = s1_now_r - grid_change_nxt;
        if (grid_meas != grid_present_nxt && grid_age > {16'd0, grid_debounce_r}) begin
          grid_present_nxt = grid_meas;
          if (grid_meas) begin
            if (outage_run_nxt) begin
              outage_dur_nxt = s1_now_r - outage_start_nxt;
              outage_run_nxt = 1'b0;
            end
            lvd_nxt = 1'b0;
            if (cyc_state_nxt == PH_IDLE) begin
              if (!mode_off(load_modes_r, CH_ROUTER)) router_en_nxt = 1'b1;
              if (!mode_off(load_modes_r, CH_ONT))    ont_en_nxt    = 1'b1;
            end
            warn_sent_nxt = 1'b0;
            ev_nxt[EV_GRID_BACK] = 1'b1;
          end else begin
            outage_start_nxt = s1_now_r;
            outage_run_nxt   = 1'b1;
            outage_count_nxt = outage_count_nxt + 32'd1;
            ev_nxt[EV_GRID_LOST] = 1'b1;
          end
        end
        // Shed loads on a low battery without grid
        if (!grid_present_nxt && !lvd_nxt && s1_vbatt_r <= batt_cutoff_r &&
            (router_en_nxt || ont_en_nxt) && cyc_state_nxt == PH_IDLE) begin
          router_en_nxt = 1'b0;
          ont_en_nxt    = 1'b0;
          lvd_nxt       = 1'b1;
          ev_nxt[EV_DISCONNECT] = 1'b1;
        end
        // Apply channel modes outside a power cycle
        if (cyc_state_nxt == PH_IDLE) begin
          if (grid_present_nxt) begin
            lvd_nxt = 1'b0;
          end else if (lvd_nxt) begin
            if (s1_vbatt_r >= batt_restore_r) lvd_nxt = 1'b0;
            else act = 1'b0;
          end
          if (act) begin
            router_en_nxt = !mode_off(load_modes_r, CH_ROUTER) && (grid_present_nxt ||
                            batt_allows(lvd_nxt, s1_vbatt_r, batt_cutoff_r, batt_restore_r));
            ont_en_nxt    = !mode_off(load_modes_r, CH_ONT) && (grid_present_nxt ||
                            batt_allows(lvd_nxt, s1_vbatt_r, batt_cutoff_r, batt_restore_r));
          end
        end
        // Raise the low-battery warning once, clear it with margin
        if (!grid_present_nxt && (router_en_nxt || ont_en_nxt) &&
            s1_vbatt_r <= batt_warn_r && !warn_sent_nxt) begin
          warn_sent_nxt = 1'b1;
          ev_nxt[EV_BATT_WARN] = 1'b1;
        end
        if ({1'b0, s1_vbatt_r} > warn_clear) warn_sent_nxt = 1'b0;
      end
      CMD_RESTART: begin
        if (s1_target_r == 2'd0) begin
          status_nxt = ST_NO_TARGET;
        end else if (cyc_state_nxt != PH_IDLE) begin
          status_nxt = ST_BUSY;
        end else if ((s1_target_r[CH_ROUTER] && mode_off(load_modes_r, CH_ROUTER)) ||
                     (s1_target_r[CH_ONT] && mode_off(load_modes_r, CH_ONT))) begin
          status_nxt = ST_MODE_OFF;
        end else if (!(grid_present_nxt ||
                       batt_allows(lvd_nxt, last_batt_nxt, batt_cutoff_r,
                                   batt_restore_r))) begin
          status_nxt = ST_BATT_LOW;
        end else begin
          cyc_auto_nxt     = s1_auto_r;
          cyc_target_nxt   = s1_target_r;
          cyc_state_nxt    = PH_WAIT_CUT;
          cyc_deadline_nxt = s1_now_r + (s1_auto_r ? AUTO_DELAY_MS : MANUAL_DELAY_MS);
          status_nxt       = ST_ACCEPTED;
        end
      end
      default: ;
    endcase

    // Battery level from the latest measurement
    if (last_batt_nxt <= batt_cutoff_r)   level_nxt = LVL_CRITICAL;
    else if (last_batt_nxt <= batt_warn_r) level_nxt = LVL_WARNING;
    else                                   level_nxt = LVL_OK;
  end

  // Advance controller state once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      router_en_r    <= 1'b0;
      ont_en_r       <= 1'b0;
      grid_present_r <= 1'b1;
      grid_cand_r    <= 1'b1;
      grid_change_r  <= 32'd0;
      lvd_r          <= 1'b0;
      warn_sent_r    <= 1'b0;
      last_batt_r    <= 16'd0;
      outage_run_r   <= 1'b0;
      outage_start_r <= 32'd0;
      outage_count_r <= 32'd0;
      outage_dur_r   <= 32'd0;
      cyc_state_r    <= PH_IDLE;
      cyc_target_r   <= 2'd0;
      cyc_deadline_r <= 32'd0;
      cyc_auto_r     <= 1'b0;
    end else if (s1_fire) begin
      router_en_r    <= router_en_nxt;
      ont_en_r       <= ont_en_nxt;
      grid_present_r <= grid_present_nxt;
      grid_cand_r    <= grid_cand_nxt;
      grid_change_r  <= grid_change_nxt;
      lvd_r          <= lvd_nxt;
      warn_sent_r    <= warn_sent_nxt;
      last_batt_r    <= last_batt_nxt;
      outage_run_r   <= outage_run_nxt;
      outage_start_r <= outage_start_nxt;
      outage_count_r <= outage_count_nxt;
      outage_dur_r   <= outage_dur_nxt;
      cyc_state_r    <= cyc_state_nxt;
      cyc_target_r   <= cyc_target_nxt;
      cyc_deadline_r <= cyc_deadline_nxt;
      cyc_auto_r     <= cyc_auto_nxt;
    end
  end

  // ------------------------------------------------------------- result
  logic        out_router_on_r, out_ont_on_r, out_grid_ok_r;
  level_t      out_level_r;
  logic        out_disc_r;
  phase_t      out_phase_r;
  status_t     out_status_r;
  logic [3:0]  out_events_r;
  logic [31:0] out_total_r, out_last_r;
  logic        out_recheck_r;

  // Hold the result while stalled, load it when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_router_on_r <= router_en_nxt;
      out_ont_on_r    <= ont_en_nxt;
      out_grid_ok_r   <= grid_present_nxt;
      out_level_r     <= level_nxt;
      out_disc_r      <= lvd_nxt;
      out_phase_r     <= cyc_state_nxt;
      out_status_r    <= status_nxt;
      out_events_r    <= ev_nxt;
      out_total_r     <= outage_count_nxt;
      out_last_r      <= outage_dur_nxt;
      out_recheck_r   <= recheck_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_router_on         = out_router_on_r;
  assign out_ont_on            = out_ont_on_r;
  assign out_grid_ok           = out_grid_ok_r;
  assign out_battery_level     = out_level_r;
  assign out_disconnect_active = out_disc_r;
  assign out_cycle_phase       = out_phase_r;
  assign out_request_status    = out_status_r;
  assign out_event_flags       = out_events_r;
  assign out_outage_total      = out_total_r;
  assign out_last_outage_ms    = out_last_r;
  assign out_recheck_network   = out_recheck_r;

  // ---------------------------------------------------------- assertions
  // An idle power cycle carries no target
  a_idle_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    (cyc_state_r == PH_IDLE) |-> (cyc_target_r == 2'd0))
    else $error("idle power cycle with a target");

  // A finished cycle leaves the hold phase; a restart in the same item may
  // open a new wait phase
  a_recheck_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_recheck_r) |-> (out_phase_r != PH_HOLD_OFF))
    else $error("recheck reported in hold phase");

  // The outage count moves only with a grid-lost event
  a_outage_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !ev_nxt[EV_GRID_LOST]) |=> (outage_count_r == $past(outage_count_r)))
    else $error("outage count changed without grid loss");

  // An item waiting on a full output stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_now_r)))
    else $error("input register lost a stalled item");

  // Grid events agree with the reported presence
  a_grid_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!out_events_r[EV_GRID_BACK] || out_grid_ok_r) &&
                     (!out_events_r[EV_GRID_LOST] || !out_grid_ok_r)))
    else $error("grid event disagrees with grid presence");

endmodule
